FILE: rtl/pws_pkg.sv
// shared constants and types for the palindrome window search block
package pws_pkg;

   localparam int MAX_WINDOW = 64;
   localparam int MAX_LENGTH = 1024;

   localparam int CHAR_W   = 8;
   localparam int LEN_W    = 7;
   localparam int WIN_IDX_W = $clog2(MAX_WINDOW);
   localparam int COUNT_W  = $clog2(MAX_LENGTH) + 1;
   localparam int POS_W    = 10;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // register index taken from the word address bit
   typedef enum logic {
      CSR_WINDOW_LENGTH = 1'b0,
      CSR_UNMAPPED      = 1'b1
   } csr_index_type;

   localparam logic [LEN_W-1:0] WINDOW_LENGTH_RESET = LEN_W'(1);

   // newest byte at index 0
   typedef logic [MAX_WINDOW-1:0][CHAR_W-1:0] window_type;

endpackage

FILE: rtl/pws_mirror_cmp.sv
// mirrored byte compare over the recent-byte window for a configured length
module pws_mirror_cmp
   import pws_pkg::*;
(
   input  window_type       window_bytes,
   input  logic [LEN_W-1:0] window_length,
   output logic             mirror_match
);

   logic [MAX_WINDOW/2-1:0] pair_ok;
   logic [LEN_W-1:0]        half_length;

   assign half_length = window_length >> 1;

   // pair j mirrors j against length-1-j; pairs past the middle are don't-care
   always_comb begin
      logic [LEN_W-1:0] partner;
      for (int j = 0; j < MAX_WINDOW/2; j++) begin
         partner = window_length - LEN_W'(1) - LEN_W'(j);
         if (LEN_W'(j) < half_length) begin
            pair_ok[j] = (window_bytes[j] == window_bytes[partner[WIN_IDX_W-1:0]]);
         end else begin
            pair_ok[j] = 1'b1;
         end
      end
   end

   assign mirror_match = &pair_ok;

endmodule

FILE: rtl/palindrome_window_search.sv
// top level of the palindrome window search block with its register port
// result path: an accepted item passes the item register, then the output register
// throughput: one item per cycle; the recent-byte shift line and the mirrored
//   compare handle a full window without iteration, stalling only while a result
//   waits in the output register and the next item also has one to give
// reset: synchronous, clears the pipeline, the byte count and the match flag and
//   sets window_length to 1; req_ready is low during reset; window bytes not cleared
module palindrome_window_search
   import pws_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   // byte stream in
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [CHAR_W-1:0]     req_char_code,
   input  logic                  req_last,

   // search result out
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_found,
   output logic [POS_W-1:0]      rsp_start_position,

   // register port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   // ------------------------------------------------------------------
   // register port: one register, written on the access phase
   // ------------------------------------------------------------------
   logic [LEN_W-1:0] window_length_ff, window_length_in;
   csr_index_type    csr_index;
   logic             csr_write;

   assign csr_index  = csr_index_type'(csr_paddr[2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      window_length_in = window_length_ff;
      csr_prdata       = '0;
      unique case (csr_index)
         CSR_WINDOW_LENGTH: begin
            csr_prdata = CSR_DATA_W'(window_length_ff);
            if (csr_write) begin
               window_length_in = csr_pwdata[LEN_W-1:0];
            end
         end
         CSR_UNMAPPED: begin
            csr_prdata = '0;
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_length_ff <= WINDOW_LENGTH_RESET;
      end else begin
         window_length_ff <= window_length_in;
      end
   end

   // ------------------------------------------------------------------
   // input stage: item register plus the recent-byte shift line
   // ------------------------------------------------------------------
   logic              s1_valid_ff, s1_valid_in;
   logic              s1_last_ff;
   window_type        window_ff;
   logic              req_accept;
   logic              s1_advance;

   assign req_accept = req_valid && req_ready;
   // no item is taken while reset holds the pipeline
   assign req_ready  = !reset && (!s1_valid_ff || s1_advance);

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   // every accepted byte shifts in; bytes past the length limit are never read
   // before the next string has written the slots it checks
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_last_ff <= req_last;
         window_ff  <= {window_ff[MAX_WINDOW-2:0], req_char_code};
      end
   end

   // ------------------------------------------------------------------
   // evaluate stage: mirrored compare, stream bookkeeping, result decision
   // ------------------------------------------------------------------
   logic               mirror_match;
   logic [COUNT_W-1:0] byte_count_ff, byte_count_in;
   logic               match_seen_ff, match_seen_in;
   logic [COUNT_W-1:0] count_inc;
   logic               stored;
   logic               length_ok;
   logic               enough_bytes;
   logic               hit;
   logic               miss;
   logic               produce;
   logic [COUNT_W-1:0] start_full;

   pws_mirror_cmp u_mirror (
      .window_bytes  (window_ff),
      .window_length (window_length_ff),
      .mirror_match  (mirror_match)
   );

   assign stored       = (byte_count_ff < COUNT_W'(MAX_LENGTH));
   assign count_inc    = byte_count_ff + COUNT_W'(1);
   assign length_ok    = (window_length_ff != '0) &&
                         (window_length_ff <= LEN_W'(MAX_WINDOW));
   assign enough_bytes = (count_inc >= COUNT_W'(window_length_ff));
   assign start_full   = count_inc - COUNT_W'(window_length_ff);

   // first palindrome window of the string, reported once
   assign hit  = s1_valid_ff && stored && !match_seen_ff && length_ok &&
                 enough_bytes && mirror_match;
   // string ends with nothing found
   assign miss = s1_valid_ff && s1_last_ff && !match_seen_ff && !hit;
   assign produce = hit || miss;

   // an item with no result never waits on the output side
   assign s1_advance = s1_valid_ff && (!produce || !rsp_valid || rsp_ready);

   always_comb begin
      byte_count_in = byte_count_ff;
      match_seen_in = match_seen_ff;
      if (s1_advance) begin
         if (s1_last_ff) begin
            byte_count_in = '0;
            match_seen_in = 1'b0;
         end else begin
            if (stored) begin
               byte_count_in = count_inc;
            end
            if (hit) begin
               match_seen_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff <= '0;
         match_seen_ff <= 1'b0;
      end else begin
         byte_count_ff <= byte_count_in;
         match_seen_ff <= match_seen_in;
      end
   end

   // ------------------------------------------------------------------
   // output register
   // ------------------------------------------------------------------
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_found_ff;
   logic [POS_W-1:0] rsp_position_ff;
   logic             rsp_load;

   assign rsp_load = s1_advance && produce;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_found_ff    <= hit;
         rsp_position_ff <= hit ? start_full[POS_W-1:0] : '0;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_found          = rsp_found_ff;
   assign rsp_start_position = rsp_position_ff;

   // ------------------------------------------------------------------
   // checks
   // ------------------------------------------------------------------
   // a not-found result always carries position zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_start_position == '0)
      else $error("not-found item with nonzero position");

   // the byte count saturates at the length limit
   assert property (@(posedge clock) disable iff (reset)
      byte_count_ff <= COUNT_W'(MAX_LENGTH))
      else $error("byte count past length limit");

   // the end of a string clears the stream state
   assert property (@(posedge clock) disable iff (reset)
      s1_advance && s1_last_ff |=> byte_count_ff == '0 && !match_seen_ff)
      else $error("stream state not cleared after last byte");

   // a result is never loaded over one that is still waiting
   assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> !rsp_valid || rsp_ready)
      else $error("result overwritten while stalled");

endmodule

FILE: tb/tb_palindrome_window_search.sv
`timescale 1ns / 1ps
// self-checking testbench for the palindrome window search block
module tb_palindrome_window_search;
   import pws_pkg::*;

   typedef logic [CHAR_W-1:0] char_type;

   // one search outcome as the block reports it
   typedef struct packed {
      logic             found;
      logic [POS_W-1:0] start;
   } search_result_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [CHAR_W-1:0]     req_char_code;
   logic                  req_last;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic                  rsp_found;
   logic [POS_W-1:0]      rsp_start_position;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   palindrome_window_search dut (.*);

   // predictor state: recent bytes by position mod window size, count, match flag
   char_type         recent_bytes [MAX_WINDOW];
   int unsigned      stored_count;
   bit               match_reported;
   logic [LEN_W-1:0] search_length;

   // outcomes still owed by the block, oldest first
   search_result_type pending_results [$];

   int unsigned      mismatch_count;
   bit               sender_gaps;
   bit               receiver_gaps;
   int unsigned      hold_off_cycles;

   always #2 clock = ~clock;

   // run limit, far beyond the slowest legal run
   initial begin
      #2_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("mismatch at %0t: %s", $realtime, what);
   endtask

   // advance the predictor by one accepted item
   task automatic track_byte(input char_type ch, input logic last_flag);
      int unsigned len;
      int unsigned first;
      bit          mirrored;
      len = search_length;
      // bytes past the length limit are neither stored nor counted
      if (stored_count < MAX_LENGTH) begin
         recent_bytes[stored_count % MAX_WINDOW] = ch;
         stored_count++;
         // only the window that ends at the newest byte is examined
         if (!match_reported && len >= 1 && len <= MAX_WINDOW && stored_count >= len) begin
            first = stored_count - len;
            mirrored = 1'b1;
            for (int j = 0; j < len / 2; j++)
               if (recent_bytes[(first + j) % MAX_WINDOW] !=
                   recent_bytes[(first + len - 1 - j) % MAX_WINDOW])
                  mirrored = 1'b0;
            if (mirrored) begin
               match_reported = 1'b1;
               pending_results.push_back(search_result_type'{1'b1, POS_W'(first)});
            end
         end
      end
      // end of string: report a miss if nothing matched, then start afresh
      if (last_flag) begin
         if (!match_reported)
            pending_results.push_back(search_result_type'{1'b0, POS_W'(0)});
         stored_count = 0;
         match_reported = 1'b0;
      end
   endtask

   // offer one item, hold it until accepted; called and returns at a falling edge
   task automatic send_byte(input char_type ch, input logic last_flag);
      int unsigned gap;
      gap = sender_gaps ? $urandom_range(0, 5) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_char_code <= ch;
      req_last      <= last_flag;
      do @(posedge clock); while (!req_ready);
      track_byte(ch, last_flag);
      @(negedge clock);
   endtask

   task automatic send_string(ref char_type text[$]);
      for (int i = 0; i < text.size(); i++)
         send_byte(text[i], i == text.size() - 1);
   endtask

   // stop offering, wait for every owed outcome, then let the pipeline empty
   // since a byte after a match gives nothing back
   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic read_search_length(input logic [LEN_W-1:0] want);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= CSR_ADDR_W'(4 * CSR_WINDOW_LENGTH);
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== CSR_DATA_W'(want))
         report_mismatch($sformatf("window_length read expected %0d got %0d",
                                   want, csr_prdata));
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
   endtask

   // register writes only happen with the block idle
   task automatic set_search_length(input logic [LEN_W-1:0] value);
      drain_results();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'(4 * CSR_WINDOW_LENGTH);
      csr_pwdata  <= CSR_DATA_W'(value);
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      search_length = value;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
      read_search_length(value);
   endtask

   // narrow draws come from a three-letter alphabet so accidental matches occur
   function automatic char_type pick_byte(input bit narrow);
      return narrow ? char_type'(8'h61 + $urandom_range(0, 2)) :
                      char_type'($urandom_range(0, 255));
   endfunction

   // mostly a planted palindrome of the wanted length inside random text,
   // some with one byte of the mirror broken, the rest plain noise
   task automatic build_string(ref char_type text[$]);
      int unsigned kind;
      int unsigned plen;
      int unsigned base;
      int unsigned flip;
      bit          narrow;
      char_type    b;
      text.delete();
      kind = $urandom_range(0, 9);
      narrow = $urandom_range(0, 1);
      if (kind < 8) begin
         plen = (search_length >= 1 && search_length <= MAX_WINDOW) ?
                search_length : $urandom_range(1, 8);
         repeat ($urandom_range(0, 6)) text.push_back(pick_byte(narrow));
         base = text.size();
         repeat (plen) text.push_back(char_type'(0));
         for (int j = 0; j < (plen + 1) / 2; j++) begin
            b = pick_byte(narrow);
            text[base + j] = b;
            text[base + plen - 1 - j] = b;
         end
         if (kind >= 6 && plen >= 2) begin
            flip = $urandom_range(0, plen / 2 - 1);
            text[base + flip] ^= char_type'(1 << $urandom_range(0, 7));
         end
         repeat ($urandom_range(0, 4)) text.push_back(pick_byte(narrow));
      end else begin
         repeat ($urandom_range(1, 12)) text.push_back(pick_byte(narrow));
      end
   endtask

   // length one straight out of reset, also with bytes after the match
   task automatic test_length_one();
      read_search_length(WINDOW_LENGTH_RESET);
      send_byte(8'h00, 1'b1);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'h7F, 1'b1);
   endtask

   // widest window, all-zero and all-one bytes, match completing on the last item
   task automatic test_full_window();
      int unsigned k;
      set_search_length(LEN_W'(MAX_WINDOW));
      send_byte(8'h5A, 1'b0);
      for (int i = 0; i < MAX_WINDOW; i++) begin
         k = (i < MAX_WINDOW / 2) ? i : MAX_WINDOW - 1 - i;
         send_byte((k % 2) ? 8'hFF : 8'h00, i == MAX_WINDOW - 1);
      end
   endtask

   // string shorter than the window, then a match on the last byte
   task automatic test_short_string();
      set_search_length(5);
      send_byte(8'h61, 1'b0);
      send_byte(8'h62, 1'b0);
      send_byte(8'h61, 1'b1);
      send_byte(8'h61, 1'b0);
      send_byte(8'h62, 1'b0);
      send_byte(8'h63, 1'b0);
      send_byte(8'h62, 1'b0);
      send_byte(8'h61, 1'b1);
   endtask

   // zero and lengths beyond the store never match
   task automatic test_disabled_lengths();
      logic [LEN_W-1:0] settings [3] = '{0, LEN_W'(MAX_WINDOW + 1), 127};
      foreach (settings[s]) begin
         set_search_length(settings[s]);
         send_byte(8'h41, 1'b1);
         send_byte(8'h41, 1'b0);
         send_byte(8'h41, 1'b1);
      end
   endtask

   // strings past the length limit: trailing bytes ignored, match at the top position
   task automatic test_long_strings();
      set_search_length(2);
      // counting bytes never repeat next to each other; the equal tail is not stored
      for (int i = 0; i < MAX_LENGTH + 6; i++)
         send_byte(i < MAX_LENGTH ? char_type'(i) : 8'h11, i == MAX_LENGTH + 5);
      // last stored byte repeats its neighbor
      for (int i = 0; i < MAX_LENGTH + 6; i++)
         send_byte(i == MAX_LENGTH - 1 ? char_type'(i - 1) : char_type'(i),
                   i == MAX_LENGTH + 5);
   endtask

   // receiver holds off while the sender keeps going, then the sender waits it out
   task automatic test_backpressure();
      set_search_length(1);
      sender_gaps = 1'b0;
      hold_off_cycles = 80;
      repeat (40) send_byte(pick_byte(1'b0), 1'b1);
      drain_results();
      receiver_gaps = 1'b1;
      sender_gaps = 1'b1;
      repeat (30) send_byte(pick_byte(1'b1), $urandom_range(0, 1));
      send_byte(pick_byte(1'b1), 1'b1);
      drain_results();
   endtask

   // random strings over a sweep of window lengths, idling switched per phase
   task automatic test_random_strings();
      int unsigned lengths [12] = '{1, 2, 3, 4, 5, 7, 11, 16, 31, 64, 0, 100};
      char_type    text [$];
      int unsigned sent;
      int unsigned phase;
      int unsigned budget;
      sent = 0;
      phase = 0;
      while (sent < 750) begin
         set_search_length(LEN_W'(lengths[phase % 12]));
         sender_gaps = ($urandom_range(0, 3) != 0);
         receiver_gaps = ($urandom_range(0, 3) != 0);
         budget = sent + 62;
         while (sent < budget) begin
            build_string(text);
            send_string(text);
            sent += text.size();
         end
         phase++;
      end
   endtask

   // result acceptance and comparison against the oldest owed outcome
   always @(posedge clock) begin : check_results
      search_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            report_mismatch($sformatf("unexpected item found=%0d start=%0d",
                                      rsp_found, rsp_start_position));
         end else begin
            want = pending_results.pop_front();
            if (rsp_found !== want.found || rsp_start_position !== want.start)
               report_mismatch($sformatf("expected found=%0d start=%0d got found=%0d start=%0d",
                                         want.found, want.start,
                                         rsp_found, rsp_start_position));
         end
      end
   end

   // receiver: random wait per item, or a long hold-off when one is requested
   initial begin : receiver
      int unsigned gap;
      rsp_ready = 1'b0;
      @(negedge clock);
      forever begin
         if (hold_off_cycles != 0) begin
            gap = hold_off_cycles;
            hold_off_cycles = 0;
         end else begin
            gap = receiver_gaps ? $urandom_range(0, 5) : 0;
         end
         if (gap != 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         // leave early when a hold-off comes in while nothing is offered
         do @(posedge clock); while (!rsp_valid && hold_off_cycles == 0);
         @(negedge clock);
      end
   end

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_char_code = '0;
      req_last = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      stored_count = 0;
      match_reported = 1'b0;
      search_length = WINDOW_LENGTH_RESET;
      mismatch_count = 0;
      sender_gaps = 1'b1;
      receiver_gaps = 1'b1;
      hold_off_cycles = 0;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_length_one();
      test_full_window();
      test_short_string();
      test_disabled_lengths();
      test_long_strings();
      test_backpressure();
      test_random_strings();
      drain_results();

      if (mismatch_count == 0 && pending_results.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
